/* sv/tuol_pkg.sv */
// Shared types and constants for the TAI minus UTC offset lookup block.
// Used by tuol_ctrl, tuol_dp and tai_utc_offset_lookup_top; depends on nothing.
`default_nettype none

package tuol_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int DAY_W  = 17;
  localparam int FRAC_W = 32;
  localparam int OFF_W  = 40;
  localparam int RATE_W = 32;
  localparam int T_W    = DAY_W + 1 + FRAC_W;
  localparam int PROD_W = 64;
  localparam int HIP_W  = T_W - FRAC_W + RATE_W;
  localparam int FULL_W = T_W + RATE_W;
  localparam int Q_W    = FULL_W - 40;
  localparam int SUM_W  = Q_W + 2;

  // Request function codes.
  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Table read address select.
  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_CUR  = 2'd1,
    RD_ENT  = 2'd2
  } rd_sel_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [DAY_W-1:0]  start_day;
    logic [OFF_W-1:0]  offset;
    logic [DAY_W-1:0]  ref_day;
    logic [RATE_W-1:0] rate;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    status_t status;
    logic    do_clear;
    logic    do_append;
    logic    start_query;
    rd_sel_t rd_sel;
    logic    idx_dec;
    logic    idx_inc;
    logic    fix_cursor;
    logic    load_entry;
    logic    mul_lo;
    logic    mul_hi;
    logic    acc;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_gt1;
    logic idx_lt_count;
    logic day_lt_start;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/tuol_ctrl.sv */
// Controller state machine for the TAI minus UTC offset lookup block.
// Depends on tuol_pkg; drives commands into tuol_dp and reads its status.
`default_nettype none

module tuol_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_func,
  output logic               in_stall,
  input  wire tuol_pkg::sts_t sts,
  output tuol_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_CHK,
    S_B_CMP,
    S_F_CHK,
    S_F_CMP,
    S_E_RD,
    S_E_LD,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A request is taken only while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = tuol_pkg::ST_OK;
    cmd.rd_sel = tuol_pkg::RD_PREV;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_FIN;
          case (in_func)
            tuol_pkg::FN_CLEAR: begin
              cmd.do_clear = 1'b1;
            end
            tuol_pkg::FN_APPEND: begin
              if (sts.full) begin
                cmd.status = tuol_pkg::ST_FULL;
              end else begin
                cmd.do_append = 1'b1;
              end
            end
            tuol_pkg::FN_QUERY: begin
              if (sts.empty) begin
                cmd.status = tuol_pkg::ST_EMPTY;
              end else begin
                cmd.start_query = 1'b1;
                state_nxt       = S_B_CHK;
              end
            end
            default: begin
              cmd.status = tuol_pkg::ST_OK;
            end
          endcase
        end
      end
      // Backward walk: read the start day just below the cursor.
      S_B_CHK: begin
        cmd.rd_sel = tuol_pkg::RD_PREV;
        state_nxt  = sts.idx_gt1 ? S_B_CMP : S_F_CHK;
      end
      S_B_CMP: begin
        if (sts.day_lt_start) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_B_CHK;
        end else begin
          state_nxt = S_F_CHK;
        end
      end
      // Forward walk: read the start day at the cursor.
      S_F_CHK: begin
        cmd.rd_sel = tuol_pkg::RD_CUR;
        state_nxt  = sts.idx_lt_count ? S_F_CMP : S_E_RD;
      end
      S_F_CMP: begin
        if (!sts.day_lt_start) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_F_CHK;
        end else begin
          state_nxt = S_E_RD;
        end
      end
      // Fetch the selected entry and settle the cursor.
      S_E_RD: begin
        cmd.rd_sel     = tuol_pkg::RD_ENT;
        cmd.fix_cursor = 1'b1;
        state_nxt      = S_E_LD;
      end
      S_E_LD: begin
        cmd.load_entry = 1'b1;
        state_nxt      = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_FIN;
      end
      // Hand the result to the output register once it has room.
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/tuol_dp.sv */
// Datapath for the TAI minus UTC offset lookup block: entry memory, cursor,
// shared multiplier, rounding, saturation and output register. Uses tuol_pkg.
`default_nettype none

module tuol_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [16:0]               in_day_number,
  input  wire logic [31:0]               in_day_fraction,
  input  wire logic signed [39:0]        in_entry_offset_in,
  input  wire logic [16:0]               in_entry_ref_day_in,
  input  wire logic [31:0]               in_entry_rate_in,
  input  wire tuol_pkg::cmd_t            cmd,
  output tuol_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [39:0]             out_offset_seconds,
  output logic [1:0]                     out_status
);

  localparam int AW     = tuol_pkg::AW;
  localparam int CW     = tuol_pkg::CW;
  localparam int T_W    = tuol_pkg::T_W;
  localparam int FULL_W = tuol_pkg::FULL_W;
  localparam int Q_W    = tuol_pkg::Q_W;
  localparam int SUM_W  = tuol_pkg::SUM_W;

  tuol_pkg::entry_t mem [tuol_pkg::TABLE_DEPTH];
  tuol_pkg::entry_t rdata_r;
  tuol_pkg::entry_t wr_entry;

  logic [CW-1:0]                    count_r;
  logic [CW-1:0]                    cursor_r;
  logic [CW-1:0]                    idx_r;
  logic [AW-1:0]                    rd_addr;
  logic [tuol_pkg::DAY_W-1:0]       day_r;
  logic [tuol_pkg::FRAC_W-1:0]      frac_r;
  logic                             neg_r;
  logic [T_W-1:0]                   tmag_r;
  logic [tuol_pkg::RATE_W-1:0]      rate_r;
  logic signed [tuol_pkg::OFF_W-1:0] off_r;
  logic [tuol_pkg::PROD_W-1:0]      lr_r;
  logic [tuol_pkg::HIP_W-1:0]       hr_r;
  logic [Q_W-1:0]                   q_r;
  tuol_pkg::status_t                status_r;

  logic [tuol_pkg::DAY_W:0]         day_diff;
  logic [T_W-1:0]                   t_val;
  logic [31:0]                      mul_a;
  logic [tuol_pkg::PROD_W-1:0]      prod;
  logic [FULL_W-1:0]                full_sum;
  logic [SUM_W-1:0]                 drift;
  logic [SUM_W-1:0]                 total;
  logic signed [tuol_pkg::OFF_W-1:0] sat_val;
  logic [CW-1:0]                    idx_fixed;

  // Status toward the controller.
  assign sts.full         = (count_r == CW'(tuol_pkg::TABLE_DEPTH));
  assign sts.empty        = (count_r == '0);
  assign sts.idx_gt1      = (idx_r > CW'(1));
  assign sts.idx_lt_count = (idx_r < count_r);
  assign sts.day_lt_start = (day_r < rdata_r.start_day);
  assign sts.out_free     = !out_valid || !out_stall;

  // Read address for the walk and for the final entry fetch.
  assign idx_fixed = (idx_r == '0) ? CW'(1) : idx_r;
  always_comb begin
    case (cmd.rd_sel)
      tuol_pkg::RD_PREV: rd_addr = AW'(idx_r - CW'(1));
      tuol_pkg::RD_CUR:  rd_addr = idx_r[AW-1:0];
      tuol_pkg::RD_ENT:  rd_addr = AW'(idx_fixed - CW'(1));
      default:           rd_addr = idx_r[AW-1:0];
    endcase
  end

  // Entry memory: written on append, read every cycle into a register.
  assign wr_entry.start_day = in_day_number;
  assign wr_entry.offset    = in_entry_offset_in;
  assign wr_entry.ref_day   = in_entry_ref_day_in;
  assign wr_entry.rate      = in_entry_rate_in;

  always_ff @(posedge clk) begin
    if (cmd.do_append) begin
      mem[count_r[AW-1:0]] <= wr_entry;
    end
    rdata_r <= mem[rd_addr];
  end

  // Entry count, cursor and walk index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.do_clear) begin
        count_r  <= '0;
        cursor_r <= '0;
      end
      if (cmd.do_append) begin
        count_r  <= count_r + CW'(1);
        cursor_r <= count_r + CW'(1);
      end
      if (cmd.start_query) begin
        idx_r <= (cursor_r > count_r) ? count_r : cursor_r;
      end
      if (cmd.idx_dec) begin
        idx_r <= idx_r - CW'(1);
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.fix_cursor) begin
        idx_r    <= idx_fixed;
        cursor_r <= idx_fixed;
      end
    end
  end

  // Signed time since the reference day, in Q.32 days.
  assign day_diff = {1'b0, day_r} - {1'b0, rdata_r.ref_day};
  assign t_val    = {day_diff, frac_r};

  // One 32 by 32 multiplier, shared between the low and high halves of |t|.
  assign mul_a = cmd.mul_hi ? 32'(tmag_r[T_W-1:32]) : tmag_r[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, rate_r};

  // Recombine partial products and round half away from zero at bit 40.
  assign full_sum = {hr_r, 32'b0} + FULL_W'(lr_r) + (FULL_W'(1) << 39);

  // Apply the sign, add the base offset and saturate to 40 bits.
  assign drift = neg_r ? (SUM_W'(0) - SUM_W'(q_r)) : SUM_W'(q_r);
  assign total = SUM_W'(off_r) + drift;
  always_comb begin
    if (total[SUM_W-1:tuol_pkg::OFF_W-1] == '0 || total[SUM_W-1:tuol_pkg::OFF_W-1] == '1) begin
      sat_val = total[tuol_pkg::OFF_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat_val = {1'b1, {(tuol_pkg::OFF_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(tuol_pkg::OFF_W-1){1'b1}}};
    end
  end

  // Request operands and arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      day_r    <= in_day_number;
      frac_r   <= in_day_fraction;
      status_r <= cmd.status;
      off_r    <= '0;
      q_r      <= '0;
      neg_r    <= 1'b0;
    end
    if (cmd.load_entry) begin
      neg_r  <= t_val[T_W-1];
      tmag_r <= t_val[T_W-1] ? (T_W'(0) - t_val) : t_val;
      rate_r <= rdata_r.rate;
      off_r  <= rdata_r.offset;
    end
    if (cmd.mul_lo) begin
      lr_r <= prod;
    end
    if (cmd.mul_hi) begin
      hr_r <= prod[tuol_pkg::HIP_W-1:0];
    end
    if (cmd.acc) begin
      q_r <= full_sum[FULL_W-1:40];
    end
  end

  // Output register; the result waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_offset_seconds <= sat_val;
      out_status         <= status_r;
    end
  end

endmodule

`default_nettype wire

/* sv/tai_utc_offset_lookup_top.sv */
// Top level of the TAI minus UTC offset lookup block.
// Instantiates tuol_ctrl and tuol_dp; uses tuol_pkg for shared types.
//
// Usage: every request on the in_ channel (valid/stall) is a clear, an append
// or a query, and gives exactly one result on the out_ channel (valid/stall):
// a signed Q8.32 offset and a status code.
// Timing: one request is worked at a time; in_stall is high from acceptance
// until the result enters the output register, and the next request can be
// taken in the cycle after that. Clear, append and requests with an error
// status go straight to the hand-off to that register. A query first walks
// the cursor back and then forward through the entry memory (a compare is
// skipped at either end of the filled table), then fetches the selected
// entry and forms the drift with the shared 32x32 multiplier (two passes).
// The result then stays in the output register while out_stall is high;
// the next request may be accepted meanwhile, and its result waits in the
// datapath until the output register is free.
// Reset: entry count and cursor go to zero and no result is pending; the
// entry memory is not cleared and needs no clearing pass.
`default_nettype none

module tai_utc_offset_lookup_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic [16:0]        in_day_number,
  input  wire logic [31:0]        in_day_fraction,
  input  wire logic signed [39:0] in_entry_offset_in,
  input  wire logic [16:0]        in_entry_ref_day_in,
  input  wire logic [31:0]        in_entry_rate_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [39:0]      out_offset_seconds,
  output logic [1:0]              out_status
);

  tuol_pkg::cmd_t cmd;
  tuol_pkg::sts_t sts;

  // Sequencer.
  tuol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, arithmetic and output register.
  tuol_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_day_number       (in_day_number),
    .in_day_fraction     (in_day_fraction),
    .in_entry_offset_in  (in_entry_offset_in),
    .in_entry_ref_day_in (in_entry_ref_day_in),
    .in_entry_rate_in    (in_entry_rate_in),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_offset_seconds  (out_offset_seconds),
    .out_status          (out_status)
  );

`ifndef SYNTHESIS
  // An accepted request blocks the input until its result is produced.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted request");

  // A result is never written over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // Appends are never written into a full table.
  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_append |-> !sts.full)
    else $error("append written into a full table");

  // The walk never reads beyond the filled part of the table.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.idx_inc |-> sts.idx_lt_count) and (cmd.idx_dec |-> sts.idx_gt1))
    else $error("cursor walk left the filled table");
`endif

endmodule

`default_nettype wire

/* tb/sv/tai_utc_offset_lookup_top_tb.sv */
// Testbench for tai_utc_offset_lookup_top: drives clear, append and query requests
// and checks every result against a leap-second table model held in a scoreboard class.
// Depends on tuol_pkg and the tai_utc_offset_lookup_top RTL.
`timescale 1ns / 1ps

// One expected result of the lookup block.
typedef struct packed {
  logic signed [39:0] offset_seconds;
  logic [1:0]         status;
} tai_offset_result_t;

// Keeps its own copy of the leap-second table and the walk cursor, predicts the
// result of every accepted request and compares results in order.
class tai_offset_scoreboard;
  logic [16:0]        entry_start [tuol_pkg::TABLE_DEPTH];
  logic signed [39:0] entry_offset [tuol_pkg::TABLE_DEPTH];
  logic [16:0]        entry_ref_day [tuol_pkg::TABLE_DEPTH];
  logic [31:0]        entry_rate [tuol_pkg::TABLE_DEPTH];
  int unsigned        entry_total;
  int unsigned        walk_pos;
  tai_offset_result_t pending_offsets[$];
  int unsigned        mismatch_count;

  function new();
    entry_total = 0;
    walk_pos = 0;
    mismatch_count = 0;
  endfunction

  // Update the table for an accepted request and queue the result it must give.
  function void note_request(logic [1:0] func, logic [16:0] day, logic [31:0] frac,
                             logic signed [39:0] off, logic [16:0] ref_day,
                             logic [31:0] rate);
    tai_offset_result_t res;
    int unsigned        idx;
    int unsigned        sel;
    longint             day_q;
    longint             ref_q;
    longint             frac_q;
    longint             span;
    longint             sum;
    logic [95:0]        span_mag;
    logic [95:0]        rate_w;
    logic [95:0]        product;
    longint             drift;
    res.offset_seconds = '0;
    res.status = tuol_pkg::ST_OK;
    case (func)
      tuol_pkg::FN_CLEAR: begin
        entry_total = 0;
        walk_pos = 0;
      end
      tuol_pkg::FN_APPEND: begin
        if (entry_total >= tuol_pkg::TABLE_DEPTH) begin
          res.status = tuol_pkg::ST_FULL;
        end else begin
          entry_start[entry_total] = day;
          entry_offset[entry_total] = off;
          entry_ref_day[entry_total] = ref_day;
          entry_rate[entry_total] = rate;
          entry_total++;
          walk_pos = entry_total;
        end
      end
      tuol_pkg::FN_QUERY: begin
        if (entry_total == 0) begin
          res.status = tuol_pkg::ST_EMPTY;
        end else begin
          // Walk back, then forward, to the last entry starting at or before the day.
          idx = walk_pos;
          if (idx > entry_total) idx = entry_total;
          while (idx > 1 && day < entry_start[idx-1]) idx--;
          while (idx < entry_total && day >= entry_start[idx]) idx++;
          if (idx == 0) idx = 1;
          walk_pos = idx;
          sel = idx - 1;

          // Drift term: round the magnitude at bit 40, ties away from zero, then sign it.
          day_q = longint'(day);
          ref_q = longint'(entry_ref_day[sel]);
          frac_q = longint'(frac);
          span = (day_q - ref_q) * 64'sd4294967296 + frac_q;
          span_mag = (span < 0) ? 96'(-span) : 96'(span);
          rate_w = 96'(entry_rate[sel]);
          product = span_mag * rate_w + (96'd1 << 39);
          drift = longint'(product >> 40);
          sum = longint'(entry_offset[sel]);
          sum = (span < 0) ? sum - drift : sum + drift;

          // Saturate to the signed 40-bit range.
          if (sum > 64'sd549755813887) sum = 64'sd549755813887;
          if (sum < -64'sd549755813888) sum = -64'sd549755813888;
          res.offset_seconds = sum[39:0];
        end
      end
      default: begin
        // The unused function code leaves the table alone and reports zero.
      end
    endcase
    pending_offsets.push_back(res);
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(logic signed [39:0] got_offset, logic [1:0] got_status);
    tai_offset_result_t want;
    if (pending_offsets.size() == 0) begin
      $display("%0t: result with nothing expected: offset %0d status %0d",
               $time, got_offset, got_status);
      mismatch_count++;
      return;
    end
    want = pending_offsets.pop_front();
    if (got_offset !== want.offset_seconds) begin
      $display("%0t: offset_seconds mismatch: expected %0d, actual %0d",
               $time, $signed(want.offset_seconds), got_offset);
      mismatch_count++;
    end
    if (got_status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, want.status, got_status);
      mismatch_count++;
    end
  endfunction

  function int unsigned pending();
    return pending_offsets.size();
  endfunction
endclass

module tai_utc_offset_lookup_top_tb;

  localparam logic [1:0]         FN_UNUSED   = 2'd3;
  localparam logic [16:0]        DAY_MAX     = 17'h1FFFF;
  localparam logic [31:0]        FRAC_MAX    = 32'hFFFF_FFFF;
  localparam logic signed [39:0] OFF_MAX     = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] OFF_MIN     = 40'sh80_0000_0000;
  localparam int unsigned        ITEM_TARGET = 1650;
  localparam int unsigned        CYCLE_LIMIT = 1000000;
  localparam int unsigned        HOLDOFF_LEN = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = tuol_pkg::FN_CLEAR;
  logic [16:0]        in_day_number = '0;
  logic [31:0]        in_day_fraction = '0;
  logic signed [39:0] in_entry_offset_in = '0;
  logic [16:0]        in_entry_ref_day_in = '0;
  logic [31:0]        in_entry_rate_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [39:0] out_offset_seconds;
  logic [1:0]         out_status;

  tai_offset_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_gap_pct = 19;
  int unsigned recv_stall_pct = 19;
  logic        holdoff_pending = 1'b0;
  int unsigned holdoff_left = 0;

  tai_utc_offset_lookup_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_day_number       (in_day_number),
    .in_day_fraction     (in_day_fraction),
    .in_entry_offset_in  (in_entry_offset_in),
    .in_entry_ref_day_in (in_entry_ref_day_in),
    .in_entry_rate_in    (in_entry_rate_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_offset_seconds  (out_offset_seconds),
    .out_status          (out_status)
  );

  always #1 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tai_utc_offset_lookup_top_tb failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (holdoff_pending) begin
      holdoff_pending = 1'b0;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check every result taken at a clock edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_offset_seconds, out_status);
    end
  end

  function automatic logic [39:0] rand40();
    return 40'({$urandom(), $urandom()});
  endfunction

  // Offer one request, with random idle cycles ahead of it, and note it once taken.
  task automatic send_request(input logic [1:0] func, input logic [16:0] day,
                              input logic [31:0] frac, input logic signed [39:0] off,
                              input logic [16:0] ref_day, input logic [31:0] rate);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_day_number <= day;
    in_day_fraction <= frac;
    in_entry_offset_in <= off;
    in_entry_ref_day_in <= ref_day;
    in_entry_rate_in <= rate;
    do @(posedge clk); while (in_stall);
    sb.note_request(func, day, frac, off, ref_day, rate);
    items_sent++;
  endtask

  task automatic send_append(input logic [16:0] day, input logic signed [39:0] off,
                             input logic [16:0] ref_day, input logic [31:0] rate);
    send_request(tuol_pkg::FN_APPEND, day, $urandom(), off, ref_day, rate);
  endtask

  task automatic send_query(input logic [16:0] day, input logic [31:0] frac);
    send_request(tuol_pkg::FN_QUERY, day, frac, rand40(),
                 17'($urandom_range(0, DAY_MAX)), $urandom());
  endtask

  // Stop offering and hold the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n_entries;
    int unsigned n_queries;
    int unsigned pick;
    int unsigned k;
    int          day_int;
    int          first_day;
    int          last_day;
    int          ref_int;
    int          qday;
    int          lo_day;
    int          hi_day;
    logic [1:0]  func;
    logic [16:0] day_sel;
    logic        holdoff_done;
    logic        pause_done;

    holdoff_done = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: empty table, unused code, extremes, rounding ties,
    // saturation both ways, days before the first entry and unsorted appends.
    send_query(17'd40000, 32'd0);
    send_request(FN_UNUSED, 17'd5, FRAC_MAX, OFF_MAX, DAY_MAX, FRAC_MAX);
    send_append(17'd100, 40'sh25_0000_0000, 17'd100, 32'd256);
    send_append(17'd200, OFF_MAX, 17'd0, FRAC_MAX);
    send_append(17'd300, OFF_MIN, DAY_MAX, FRAC_MAX);
    send_query(17'd50, 32'd0);
    send_query(17'd100, 32'h8000_0000);
    send_query(17'd99, 32'h8000_0000);
    send_query(17'd250, FRAC_MAX);
    send_query(17'd300, 32'd0);
    send_query(DAY_MAX, FRAC_MAX);
    send_query(17'd0, 32'd0);
    send_append(17'd10, 40'sd0, DAY_MAX, 32'd0);
    send_query(17'd20, 32'h1234_5678);
    send_query(17'd350, 32'hFFFF_0000);
    send_request(FN_UNUSED, 17'd0, 32'd0, 40'sd0, 17'd0, 32'd0);
    send_query(17'd150, 32'd1);
    send_request(tuol_pkg::FN_CLEAR, DAY_MAX, FRAC_MAX, OFF_MIN, DAY_MAX, FRAC_MAX);
    send_query(17'd150, 32'd1);
    send_append(DAY_MAX, 40'sd0, 17'd0, 32'h5555_5555);
    send_query(DAY_MAX, 32'hAAAA_AAAA);
    send_query(17'd0, FRAC_MAX);
    drain_results();

    // Random part: mostly clear, sorted appends and queries that walk the table.
    while (items_sent < ITEM_TARGET) begin
      if (!holdoff_done && items_sent >= 600) begin
        holdoff_pending = 1'b1;
        holdoff_done = 1'b1;
      end
      if (!pause_done && items_sent >= 800) begin
        drain_results();
        pause_done = 1'b1;
      end
      if (items_sent >= 1000 && items_sent < 1250) begin
        sender_gap_pct = 0;
        recv_stall_pct = 0;
      end else begin
        sender_gap_pct = 19;
        recv_stall_pct = 19;
      end

      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_request(tuol_pkg::FN_CLEAR, 17'($urandom_range(0, DAY_MAX)), $urandom(),
                     rand40(), 17'($urandom_range(0, DAY_MAX)), $urandom());
        if ($urandom_range(0, 99) < 3) begin
          n_entries = tuol_pkg::TABLE_DEPTH + $urandom_range(0, 3);
        end else begin
          n_entries = $urandom_range(1, 6);
        end
        day_int = $urandom_range(0, 129000);
        first_day = day_int;
        last_day = day_int;
        for (k = 0; k < n_entries; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            ref_int = day_int - int'($urandom_range(0, 3000));
            if (ref_int < 0) ref_int = 0;
            send_append(17'(day_int), {8'($urandom_range(10, 37)), 32'($urandom())},
                        17'(ref_int), 32'($urandom_range(0, 1 << 20)));
          end else begin
            send_append(17'(day_int), rand40(), 17'($urandom_range(0, DAY_MAX)),
                        $urandom());
          end
          last_day = day_int;
          day_int = day_int + int'($urandom_range(0, 30));
          if (day_int > int'(DAY_MAX)) day_int = int'(DAY_MAX);
        end

        // Queries around the table, partly moving forward in small steps.
        lo_day = (first_day >= 10) ? first_day - 10 : 0;
        hi_day = (last_day + 10 > int'(DAY_MAX)) ? int'(DAY_MAX) : last_day + 10;
        n_queries = $urandom_range(2, 10);
        qday = lo_day;
        for (k = 0; k < n_queries; k++) begin
          if (k == 0 || $urandom_range(0, 1) == 1) begin
            qday = $urandom_range(lo_day, hi_day);
          end else begin
            qday = qday + int'($urandom_range(0, 25));
            if (qday > int'(DAY_MAX)) qday = int'(DAY_MAX);
          end
          send_query(17'(qday), $urandom());
        end
      end else begin
        // Noise: any function code with unconstrained fields.
        pick = $urandom_range(0, 99);
        if (pick < 45) func = tuol_pkg::FN_QUERY;
        else if (pick < 85) func = tuol_pkg::FN_APPEND;
        else if (pick < 95) func = tuol_pkg::FN_CLEAR;
        else func = FN_UNUSED;
        if ($urandom_range(0, 9) == 0) day_sel = ($urandom_range(0, 1) == 1) ? DAY_MAX : '0;
        else day_sel = 17'($urandom_range(0, DAY_MAX));
        send_request(func, day_sel, $urandom(), rand40(), 17'($urandom_range(0, DAY_MAX)),
                     $urandom());
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("tai_utc_offset_lookup_top_tb passed");
    end else begin
      $display("tai_utc_offset_lookup_top_tb failed");
    end
    $finish;
  end

endmodule
